// ===== design/ipp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipp_pkg
// Shared types and constants of the projection profile core.
// ----------------------------------------------------------------------------
package ipp_pkg;

    // Default store depths
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Field widths fixed by the interface
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int PIX_W      = 8;
    localparam int CNT_W      = 8;
    localparam int IDX_W      = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Reset value of both size registers
    localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 11'd1024;

    // Command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Background gray level
    localparam logic [PIX_W-1:0] BACKGROUND = 8'd255;

    // Column store request for one accepted item
    typedef struct packed {
        logic upd;  // pixel update of a column count
        logic inc;  // pixel is foreground
    } t_col_cmd;

    // Readout request travelling with the store read
    typedef struct packed {
        logic             valid;
        logic             is_row;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_rd_tag;

endpackage

// ===== design/ipp_col_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipp_col_store
// Column count memory with a read-modify-write stage and a one-deep bypass.
// ----------------------------------------------------------------------------
module ipp_col_store #(
    parameter int MAX_WIDTH = ipp_pkg::DEF_MAX_WIDTH,
    parameter int COL_AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ipp_pkg::t_col_cmd        i_cmd,
    input  logic [COL_AW-1:0]        i_addr,
    input  logic                     i_clr_en,
    input  logic [COL_AW-1:0]        i_clr_addr,
    output logic [ipp_pkg::CNT_W-1:0] o_rd_data
);

    logic [ipp_pkg::CNT_W-1:0] r_mem [MAX_WIDTH];

    logic [ipp_pkg::CNT_W-1:0] r_rd_data;
    logic [COL_AW-1:0]         r_addr;
    logic                      r_upd;
    logic                      r_inc;

    logic                      r_byp_valid;
    logic [COL_AW-1:0]         r_byp_addr;
    logic [ipp_pkg::CNT_W-1:0] r_byp_data;

    logic [ipp_pkg::CNT_W-1:0] cur;
    logic [ipp_pkg::CNT_W-1:0] sum;

    // Count as of now: the write of the item just before is not yet visible
    always_comb begin
        if (r_byp_valid && (r_byp_addr == r_addr)) begin
            cur = r_byp_data;
        end else begin
            cur = r_rd_data;
        end
        sum = cur + ipp_pkg::CNT_W'(r_inc);
    end

    assign o_rd_data = cur;

    // Memory: read at accept, write back in the cycle after, or clear
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_addr];
        r_addr    <= i_addr;
        r_inc     <= i_cmd.inc;
        if (i_clr_en) begin
            r_mem[i_clr_addr] <= '0;
        end else if (r_upd) begin
            r_mem[r_addr] <= sum;
        end
        r_byp_addr <= r_addr;
        r_byp_data <= sum;
    end

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd       <= 1'b0;
            r_byp_valid <= 1'b0;
        end else begin
            r_upd       <= i_cmd.upd;
            r_byp_valid <= r_upd && !i_clr_en;
        end
    end

endmodule

// ===== design/ipp_row_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipp_row_store
// Row count memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ipp_row_store #(
    parameter int MAX_HEIGHT = ipp_pkg::DEF_MAX_HEIGHT,
    parameter int ROW_AW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [ROW_AW-1:0]         i_wr_addr,
    input  logic [ipp_pkg::CNT_W-1:0] i_wr_data,
    input  logic [ROW_AW-1:0]         i_rd_addr,
    output logic [ipp_pkg::CNT_W-1:0] o_rd_data
);

    logic [ipp_pkg::CNT_W-1:0] r_mem [MAX_HEIGHT];
    logic [ipp_pkg::CNT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/ipp_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipp_seq
// Size registers, raster and readout positions, row accumulation and the
// store clearing sweep.
// ----------------------------------------------------------------------------
module ipp_seq #(
    parameter int MAX_WIDTH  = ipp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ipp_pkg::DEF_MAX_HEIGHT,
    parameter int COL_AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int ROW_AW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_command,
    input  logic [ipp_pkg::PIX_W-1:0]      i_pixel_value,
    input  logic                           i_cfg_we,
    input  logic [ipp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ipp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_busy,
    output ipp_pkg::t_col_cmd              o_col_cmd,
    output logic [COL_AW-1:0]              o_col_addr,
    output logic                           o_col_clr_en,
    output logic [COL_AW-1:0]              o_col_clr_addr,
    output logic                           o_row_wr_en,
    output logic [ROW_AW-1:0]              o_row_wr_addr,
    output logic [ipp_pkg::CNT_W-1:0]      o_row_wr_data,
    output logic [ROW_AW-1:0]              o_row_rd_addr,
    output ipp_pkg::t_rd_tag               o_tag
);

    localparam int MAX_DEPTH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CLRW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int WBITS     = $clog2(MAX_WIDTH + 1);
    localparam int HBITS     = $clog2(MAX_HEIGHT + 1);
    localparam int RBITS     = $clog2(MAX_WIDTH + MAX_HEIGHT);

    // Configuration and frame state
    logic [ipp_pkg::CFG_DATA_W-1:0] r_cfg_w;
    logic [ipp_pkg::CFG_DATA_W-1:0] r_cfg_h;
    logic [COL_AW-1:0]              r_col,  n_col;
    logic [ROW_AW-1:0]              r_row,  n_row;
    logic [ipp_pkg::CNT_W-1:0]      r_cur,  n_cur;
    logic [RBITS-1:0]               r_rpos, n_rpos;
    logic                           r_full, n_full;
    logic                           r_clearing, n_clearing;
    logic [CLRW-1:0]                r_clr_cnt, n_clr_cnt;
    ipp_pkg::t_rd_tag               r_tag, n_tag;

    logic [WBITS-1:0]          w_eff;
    logic [HBITS-1:0]          h_eff;
    logic                      is_pix;
    logic                      is_rd;
    logic                      pix_inc;
    logic                      row_end;
    logic                      frame_end;
    logic [ipp_pkg::CNT_W-1:0] row_sum;
    logic                      rd_last;
    logic                      rd_col;
    logic [31:0]               rd_idx;

    // Effective sizes: zero acts as one, large values saturate
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WBITS'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_eff = WBITS'(MAX_WIDTH);
        end else begin
            w_eff = WBITS'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = HBITS'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            h_eff = HBITS'(MAX_HEIGHT);
        end else begin
            h_eff = HBITS'(r_cfg_h);
        end
    end

    // Decode of the accepted item
    always_comb begin
        is_pix    = i_accept && (i_command == ipp_pkg::CMD_PIXEL) && !r_full;
        is_rd     = i_accept && (i_command == ipp_pkg::CMD_READ);
        pix_inc   = (i_pixel_value != ipp_pkg::BACKGROUND);
        row_end   = (32'(r_col) + 32'd1) >= 32'(w_eff);
        frame_end = (32'(r_row) + 32'd1) >= 32'(h_eff);
        row_sum   = r_cur + ipp_pkg::CNT_W'(pix_inc);
        rd_last   = 32'(r_rpos) >= (32'(w_eff) + 32'(h_eff) - 32'd1);
        rd_col    = 32'(r_rpos) < 32'(w_eff);
        priority if (rd_last) begin
            rd_idx = 32'(h_eff) - 32'd1;
        end else if (rd_col) begin
            rd_idx = 32'(r_rpos);
        end else begin
            rd_idx = 32'(r_rpos) - 32'(w_eff);
        end
    end

    // Next state of positions, readout and clearing sweep
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_cur      = r_cur;
        n_rpos     = r_rpos;
        n_full     = r_full;
        n_clearing = r_clearing;
        n_clr_cnt  = r_clr_cnt;

        n_tag        = '0;
        n_tag.valid  = is_rd;
        n_tag.is_row = rd_last || !rd_col;
        n_tag.idx    = ipp_pkg::IDX_W'(rd_idx);
        n_tag.last   = rd_last;

        if (r_clearing) begin
            n_clr_cnt = r_clr_cnt + CLRW'(1);
            if (32'(r_clr_cnt) == 32'(MAX_DEPTH - 1)) begin
                n_clearing = 1'b0;
                n_clr_cnt  = '0;
            end
        end

        if (is_pix) begin
            if (row_end) begin
                n_cur = '0;
                n_col = '0;
                if (frame_end) begin
                    n_row  = '0;
                    n_full = 1'b1;
                end else begin
                    n_row = r_row + ROW_AW'(1);
                end
            end else begin
                n_cur = row_sum;
                n_col = r_col + COL_AW'(1);
            end
        end

        if (is_rd) begin
            if (rd_last) begin
                n_col      = '0;
                n_row      = '0;
                n_cur      = '0;
                n_rpos     = '0;
                n_full     = 1'b0;
                n_clearing = 1'b1;
                n_clr_cnt  = '0;
            end else begin
                n_rpos = r_rpos + RBITS'(1);
            end
        end
    end

    // Requests to the stores
    always_comb begin
        o_col_cmd.upd = is_pix;
        o_col_cmd.inc = pix_inc;
        if (is_pix) begin
            o_col_addr = r_col;
        end else begin
            o_col_addr = COL_AW'(rd_idx);
        end
        o_row_rd_addr = ROW_AW'(rd_idx);

        o_col_clr_en   = r_clearing && (32'(r_clr_cnt) < 32'(MAX_WIDTH));
        o_col_clr_addr = COL_AW'(r_clr_cnt);

        if (r_clearing) begin
            o_row_wr_en   = 32'(r_clr_cnt) < 32'(MAX_HEIGHT);
            o_row_wr_addr = ROW_AW'(r_clr_cnt);
            o_row_wr_data = '0;
        end else begin
            o_row_wr_en   = is_pix && row_end;
            o_row_wr_addr = r_row;
            o_row_wr_data = row_sum;
        end
    end

    assign o_busy = r_clearing;
    assign o_tag  = r_tag;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= ipp_pkg::CFG_SIZE_RESET;
            r_cfg_h    <= ipp_pkg::CFG_SIZE_RESET;
            r_col      <= '0;
            r_row      <= '0;
            r_cur      <= '0;
            r_rpos     <= '0;
            r_full     <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_tag      <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == ipp_pkg::CFG_FRAME_WIDTH)) begin
                r_cfg_w <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == ipp_pkg::CFG_FRAME_HEIGHT)) begin
                r_cfg_h <= i_cfg_data;
            end
            r_col      <= n_col;
            r_row      <= n_row;
            r_cur      <= n_cur;
            r_rpos     <= n_rpos;
            r_full     <= n_full;
            r_clearing <= n_clearing;
            r_clr_cnt  <= n_clr_cnt;
            r_tag      <= n_tag;
        end
    end

endmodule

// ===== design/image_projection_profile_core.sv =====
`timescale 1ns / 1ps
// A read request's result is registered in the store read and tag, then in the result register that drives the strobe.
// Throughput: one request per cycle while busy is low; the column store read-modify-write is pipelined.
// Reset (and the final row read) starts a clearing sweep over every address of both
// stores, during which busy is high and no request is taken.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// image_projection_profile_core
// Column and row counts of non-background pixels, read back on request.
// ----------------------------------------------------------------------------
module image_projection_profile_core #(
    parameter int MAX_WIDTH  = ipp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ipp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [ipp_pkg::PIX_W-1:0]      i_pixel_value,
    input  logic                           i_cfg_we,
    input  logic [ipp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ipp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    output logic [ipp_pkg::CNT_W-1:0]      o_profile_count,
    output logic                           o_is_row_entry,
    output logic [ipp_pkg::IDX_W-1:0]      o_entry_index,
    output logic                           o_last_entry
);

    localparam int COL_AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic                      accept;
    ipp_pkg::t_col_cmd         col_cmd;
    logic [COL_AW-1:0]         col_addr;
    logic                      col_clr_en;
    logic [COL_AW-1:0]         col_clr_addr;
    logic [ipp_pkg::CNT_W-1:0] col_rd_data;
    logic                      row_wr_en;
    logic [ROW_AW-1:0]         row_wr_addr;
    logic [ipp_pkg::CNT_W-1:0] row_wr_data;
    logic [ROW_AW-1:0]         row_rd_addr;
    logic [ipp_pkg::CNT_W-1:0] row_rd_data;
    ipp_pkg::t_rd_tag          tag;

    logic                      r_valid;
    logic [ipp_pkg::CNT_W-1:0] r_count;
    logic                      r_is_row;
    logic [ipp_pkg::IDX_W-1:0] r_index;
    logic                      r_last;

    assign accept = start && !busy;

    ipp_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_AW     (COL_AW),
        .ROW_AW     (ROW_AW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_command      (i_command),
        .i_pixel_value  (i_pixel_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_busy         (busy),
        .o_col_cmd      (col_cmd),
        .o_col_addr     (col_addr),
        .o_col_clr_en   (col_clr_en),
        .o_col_clr_addr (col_clr_addr),
        .o_row_wr_en    (row_wr_en),
        .o_row_wr_addr  (row_wr_addr),
        .o_row_wr_data  (row_wr_data),
        .o_row_rd_addr  (row_rd_addr),
        .o_tag          (tag)
    );

    ipp_col_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_AW    (COL_AW)
    ) u_col_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (col_cmd),
        .i_addr     (col_addr),
        .i_clr_en   (col_clr_en),
        .i_clr_addr (col_clr_addr),
        .o_rd_data  (col_rd_data)
    );

    ipp_row_store #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .ROW_AW     (ROW_AW)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_wr_en   (row_wr_en),
        .i_wr_addr (row_wr_addr),
        .i_wr_data (row_wr_data),
        .i_rd_addr (row_rd_addr),
        .o_rd_data (row_rd_data)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= tag.valid;
        end
        r_count  <= tag.is_row ? row_rd_data : col_rd_data;
        r_is_row <= tag.is_row;
        r_index  <= tag.idx;
        r_last   <= tag.last;
    end

    assign o_valid         = r_valid;
    assign o_profile_count = r_count;
    assign o_is_row_entry  = r_is_row;
    assign o_entry_index   = r_index;
    assign o_last_entry    = r_last;

endmodule
